[rtl/core/fcr_pkg.sv]
// Package for the framed command receiver: frame constants, kind codes and
// the result record shared by the decoder and the top level.
// No dependencies.
`timescale 1ns / 1ps

package fcr_pkg;

  // Header positions 1..HdrBytes-1 are stored; position 0 is never written.
  localparam int HdrBytes = 8;

  localparam logic [7:0]  StartByte  = 8'd254;
  localparam logic [7:0]  CmdRun     = 8'h72;  // 'r'
  localparam logic [7:0]  CmdStop    = 8'h73;  // 's'
  localparam logic [7:0]  CmdTx      = 8'h74;  // 't'
  localparam logic [15:0] PpmReset   = 16'd1900;
  localparam logic [14:0] SpeedScale = 15'd100;

  localparam logic [7:0] TypeCmd   = 8'd1;
  localparam logic [7:0] TypeParam = 8'd2;
  localparam logic [7:0] TypeMotor = 8'd3;

  localparam logic [1:0] TxModeLast = 2'd2;

  typedef enum logic [1:0] {
    KIND_UNKNOWN = 2'd0,
    KIND_CMD     = 2'd1,
    KIND_PARAM   = 2'd2,
    KIND_MOTOR   = 2'd3
  } frame_kind_e;

  typedef logic [HdrBytes-1:1][7:0] hdr_t;

  typedef struct packed {
    frame_kind_e frame_kind;
    logic        checksum_error;
    logic        running;
    logic [1:0]  tx_mode;
    logic [23:0] position_reference;
    logic [14:0] speed_limit;
    logic [7:0]  position_param;
    logic [7:0]  gain_p_raw;
    logic [7:0]  gain_i_raw;
    logic [7:0]  gain_d_raw;
    logic [7:0]  motor_id;
    logic [7:0]  motor_dir;
  } fcr_result_t;

endpackage

[rtl/core/fcr_rx_if.sv]
// Receive channel of the framed command receiver: one serial byte per word.
// Depends on nothing.
`timescale 1ns / 1ps

interface fcr_rx_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

[rtl/core/fcr_res_if.sv]
// Result channel of the framed command receiver: one decoded frame per word.
// Depends on fcr_pkg for the kind type.
`timescale 1ns / 1ps

interface fcr_res_if
  import fcr_pkg::*;
;
  logic        valid;
  logic        ready;
  frame_kind_e frame_kind;
  logic        checksum_error;
  logic        running;
  logic [1:0]  tx_mode;
  logic [23:0] position_reference;
  logic [14:0] speed_limit;
  logic [7:0]  position_param;
  logic [7:0]  gain_p_raw;
  logic [7:0]  gain_i_raw;
  logic [7:0]  gain_d_raw;
  logic [7:0]  motor_id;
  logic [7:0]  motor_dir;

  modport source (
    output valid, output frame_kind, output checksum_error, output running,
    output tx_mode, output position_reference, output speed_limit,
    output position_param, output gain_p_raw, output gain_i_raw,
    output gain_d_raw, output motor_id, output motor_dir,
    input  ready
  );
  modport sink (
    input  valid, input frame_kind, input checksum_error, input running,
    input  tx_mode, input position_reference, input speed_limit,
    input  position_param, input gain_p_raw, input gain_i_raw,
    input  gain_d_raw, input motor_id, input motor_dir,
    output ready
  );
endinterface

[rtl/core/fcr_decode.sv]
// Combinational decoder for a completed frame: type dispatch, checks,
// scaling multiplies and the next run and transmit state.
// Depends on fcr_pkg.
`timescale 1ns / 1ps

module fcr_decode
  import fcr_pkg::*;
(
  input  hdr_t        hdr_i,          // positions 1..7 with the last byte merged
  input  logic [7:0]  last_byte_i,
  input  logic [7:0]  payload_sum_i,  // sum of positions 2..L-1
  input  logic        run_i,
  input  logic [1:0]  tx_mode_i,
  input  logic [15:0] ppm_i,
  output fcr_result_t res_o
);

  logic [7:0] motor_sum;

  assign motor_sum = hdr_i[2] + hdr_i[3];

  always_comb begin
    res_o = '0;
    res_o.running = run_i;
    res_o.tx_mode = tx_mode_i;
    case (hdr_i[1])
      TypeCmd: begin
        res_o.frame_kind = KIND_CMD;
        if (hdr_i[2] == CmdRun) begin
          res_o.running = 1'b1;
        end else if (hdr_i[2] == CmdStop) begin
          res_o.running = 1'b0;
        end else if (hdr_i[2] == CmdTx) begin
          res_o.tx_mode = (tx_mode_i >= TxModeLast) ? 2'd0 : tx_mode_i + 2'd1;
        end
      end
      TypeParam: begin
        res_o.frame_kind = KIND_PARAM;
        if (payload_sum_i == last_byte_i) begin
          res_o.position_reference = {16'd0, hdr_i[2]} * {8'd0, ppm_i};
          res_o.speed_limit        = {7'd0, hdr_i[3]} * SpeedScale;
          res_o.position_param     = hdr_i[4];
          res_o.gain_p_raw         = hdr_i[5];
          res_o.gain_i_raw         = hdr_i[6];
          res_o.gain_d_raw         = hdr_i[7];
        end else begin
          res_o.checksum_error = 1'b1;
        end
      end
      TypeMotor: begin
        res_o.frame_kind = KIND_MOTOR;
        if (hdr_i[4] == motor_sum) begin
          res_o.motor_id  = hdr_i[2];
          res_o.motor_dir = hdr_i[3];
        end else begin
          res_o.checksum_error = 1'b1;
        end
      end
      default: begin
        res_o.frame_kind = KIND_UNKNOWN;
      end
    endcase
  end

endmodule

[rtl/core/framed_command_receiver.sv]
// Top level of the framed command receiver: frame tracking, header store,
// running sum, run and transmit state, and the result register.
// Depends on fcr_pkg, fcr_rx_if, fcr_res_if and fcr_decode.
`timescale 1ns / 1ps

//  Channel   Direction  Word                            Handshake
//  rx_i      in         one serial byte (rx_byte)       valid / ready
//  res_o     out        one decoded frame, 12 fields    valid / ready
//  cfg       in         pulses_per_metre, 16 bits       cfg_we_i, no wait
//
// Every accepted byte is handled in the cycle it is accepted; a byte that
// completes a frame puts its result on res_o in the next cycle, so one byte per
// cycle is sustained unless res_o stalls. The result register is the only
// buffer: rx_i is ready whenever that register is empty or is being emptied
// in the same cycle; a stall on res_o holds the input off only while a result waits.
// Reset clears the frame tracking, the header store, the run and transmit
// state and sets pulses_per_metre to 1900.

module framed_command_receiver
  import fcr_pkg::*;
(
  input  logic          clk_i,
  input  logic          rst_ni,
  fcr_rx_if.sink        rx_i,
  fcr_res_if.source     res_o,
  input  logic          cfg_we_i,
  input  logic [15:0]   cfg_wdata_i
);

  // Frame tracking. A write position of zero means the length byte is next.
  logic        in_frame_q, in_frame_d;
  logic [7:0]  write_pos_q, write_pos_d;
  logic [7:0]  frame_len_q, frame_len_d;
  logic [7:0]  payload_sum_q, payload_sum_d;
  hdr_t        hdr_q, hdr_d;
  logic        run_q, run_d;
  logic [1:0]  tx_mode_q, tx_mode_d;
  logic [15:0] ppm_q;

  // Result register.
  logic        res_valid_q, res_valid_d;
  fcr_result_t res_q;

  logic        rx_acc;
  logic        is_start;
  logic        mid_byte;
  logic        last_byte;
  hdr_t        hdr_merged;
  fcr_result_t dec_res;

  assign rx_i.ready = !res_valid_q || res_o.ready;
  assign rx_acc     = rx_i.valid && rx_i.ready;

  assign is_start  = (rx_i.rx_byte == StartByte);
  // A byte strictly inside the frame, and the byte at position L. A length of
  // zero never matches either, so such a frame just soaks up bytes.
  assign mid_byte  = in_frame_q && !is_start && (write_pos_q != 8'd0)
                     && (write_pos_q < frame_len_q);
  assign last_byte = in_frame_q && !is_start && (write_pos_q != 8'd0)
                     && (write_pos_q == frame_len_q);

  // The completing byte is seen by the decoder at its own position.
  always_comb begin
    hdr_merged = hdr_q;
    for (int j = 1; j < HdrBytes; j++) begin
      if (write_pos_q == 8'(j)) begin
        hdr_merged[j] = rx_i.rx_byte;
      end
    end
  end

  fcr_decode u_decode (
    .hdr_i         (hdr_merged),
    .last_byte_i   (rx_i.rx_byte),
    .payload_sum_i (payload_sum_q),
    .run_i         (run_q),
    .tx_mode_i     (tx_mode_q),
    .ppm_i         (ppm_q),
    .res_o         (dec_res)
  );

  always_comb begin
    in_frame_d    = in_frame_q;
    write_pos_d   = write_pos_q;
    frame_len_d   = frame_len_q;
    payload_sum_d = payload_sum_q;
    hdr_d         = hdr_q;
    run_d         = run_q;
    tx_mode_d     = tx_mode_q;
    if (rx_acc) begin
      if (is_start) begin
        in_frame_d    = 1'b1;
        write_pos_d   = 8'd0;
        frame_len_d   = 8'd0;
        payload_sum_d = 8'd0;
        hdr_d         = '0;
      end else if (in_frame_q && write_pos_q == 8'd0) begin
        frame_len_d = rx_i.rx_byte;
        write_pos_d = 8'd1;
      end else if (mid_byte) begin
        hdr_d = hdr_merged;
        if (write_pos_q >= 8'd2) begin
          payload_sum_d = payload_sum_q + rx_i.rx_byte;
        end
        write_pos_d = write_pos_q + 8'd1;
      end else if (last_byte) begin
        in_frame_d = 1'b0;
        hdr_d      = hdr_merged;
        run_d      = dec_res.running;
        tx_mode_d  = dec_res.tx_mode;
      end
    end
  end

  always_comb begin
    res_valid_d = res_valid_q;
    if (!res_valid_q || res_o.ready) begin
      res_valid_d = rx_acc && last_byte;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_frame_q    <= 1'b0;
      write_pos_q   <= 8'd0;
      frame_len_q   <= 8'd0;
      payload_sum_q <= 8'd0;
      hdr_q         <= '0;
      run_q         <= 1'b0;
      tx_mode_q     <= 2'd0;
      ppm_q         <= PpmReset;
      res_valid_q   <= 1'b0;
    end else begin
      in_frame_q    <= in_frame_d;
      write_pos_q   <= write_pos_d;
      frame_len_q   <= frame_len_d;
      payload_sum_q <= payload_sum_d;
      hdr_q         <= hdr_d;
      run_q         <= run_d;
      tx_mode_q     <= tx_mode_d;
      res_valid_q   <= res_valid_d;
      if (cfg_we_i) begin
        ppm_q <= cfg_wdata_i;
      end
    end
  end

  // Payload of the result register; loaded only when a frame completes.
  always_ff @(posedge clk_i) begin
    if (rx_acc && last_byte) begin
      res_q <= dec_res;
    end
  end

  assign res_o.valid              = res_valid_q;
  assign res_o.frame_kind         = res_q.frame_kind;
  assign res_o.checksum_error     = res_q.checksum_error;
  assign res_o.running            = res_q.running;
  assign res_o.tx_mode            = res_q.tx_mode;
  assign res_o.position_reference = res_q.position_reference;
  assign res_o.speed_limit        = res_q.speed_limit;
  assign res_o.position_param     = res_q.position_param;
  assign res_o.gain_p_raw         = res_q.gain_p_raw;
  assign res_o.gain_i_raw         = res_q.gain_i_raw;
  assign res_o.gain_d_raw         = res_q.gain_d_raw;
  assign res_o.motor_id           = res_q.motor_id;
  assign res_o.motor_dir          = res_q.motor_dir;

endmodule

[rtl/core/fcr_checker.sv]
// Port-level checks for the framed command receiver, bound to the top level.
// Depends on fcr_pkg and framed_command_receiver.
`timescale 1ns / 1ps

module fcr_checker
  import fcr_pkg::*;
(
  input logic        clk_i,
  input logic        rst_ni,
  input logic        rx_valid_i,
  input logic        rx_ready_i,
  input logic [7:0]  rx_byte_i,
  input logic        res_valid_i,
  input logic        res_ready_i,
  input frame_kind_e frame_kind_i,
  input logic        checksum_error_i,
  input logic [1:0]  tx_mode_i
);

  logic rx_acc;
  logic res_stall;

  assign rx_acc    = rx_valid_i && rx_ready_i;
  assign res_stall = res_valid_i && !res_ready_i;

  // A waiting result stays offered.
  a_res_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_stall |=> res_valid_i)
    else $error("result dropped while stalled");

  // A new result needs an accepted byte in the cycle before.
  a_res_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!rx_acc && !res_stall) |=> !res_valid_i)
    else $error("result without an accepted byte");

  // A start byte never completes a frame.
  a_start_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rx_acc && rx_byte_i == StartByte && !res_stall) |=> !res_valid_i)
    else $error("result after a start byte");

  a_tx_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i |-> tx_mode_i != 2'd3)
    else $error("transmit mode out of range");

  a_err_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_i && checksum_error_i) |->
      (frame_kind_i == KIND_PARAM || frame_kind_i == KIND_MOTOR))
    else $error("check error on a frame kind without a check");

endmodule

bind framed_command_receiver fcr_checker u_fcr_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .rx_valid_i       (rx_i.valid),
  .rx_ready_i       (rx_i.ready),
  .rx_byte_i        (rx_i.rx_byte),
  .res_valid_i      (res_o.valid),
  .res_ready_i      (res_o.ready),
  .frame_kind_i     (res_o.frame_kind),
  .checksum_error_i (res_o.checksum_error),
  .tx_mode_i        (res_o.tx_mode)
);
